[hw/rtl/tcf_pkg.sv]
// shared types, constants and step tables for the tick count to calendar converter
`default_nettype none

package tcf_pkg;

  localparam int TICK_W  = 64;
  localparam int REM_W   = 40;
  localparam int DAYS_W  = 25;
  localparam int ALU_W   = REM_W + 1;
  localparam int STEP_W  = 6;
  localparam int HIST_W  = 14;

  localparam int DIV_STEPS   = 25;
  localparam int YEAR_STEPS  = 14;
  localparam int MONTH_STEPS = 11;
  localparam int TIME_STEPS  = 37;

  localparam logic [REM_W-1:0] DAY_TICKS      = 40'd864000000000;
  localparam logic [REM_W-1:0] TICKS_PER_HOUR = 40'd36000000000;
  localparam logic [REM_W-1:0] TICKS_PER_MIN  = 40'd600000000;
  localparam logic [REM_W-1:0] TICKS_PER_SEC  = 40'd10000000;
  localparam logic [REM_W-1:0] TICKS_PER_MS   = 40'd10000;
  localparam logic [REM_W-1:0] TICKS_PER_US   = 40'd10;

  localparam logic [DAYS_W-1:0] DAYS_LIMIT = 25'd3652059;

  localparam logic [21:0] DAYS_PER_400Y = 22'd146097;
  localparam logic [21:0] DAYS_PER_100Y = 22'd36524;
  localparam logic [21:0] DAYS_PER_4Y   = 22'd1461;
  localparam logic [21:0] DAYS_PER_1Y   = 22'd365;

  localparam logic [13:0] YEARS_400 = 14'd400;
  localparam logic [13:0] YEARS_100 = 14'd100;
  localparam logic [13:0] YEARS_4   = 14'd4;
  localparam logic [13:0] YEARS_1   = 14'd1;

  localparam logic [19:0] US_PER_MS = 20'd1000;

  localparam logic [4:0] N4_CENTURY = 5'd24;
  localparam logic [3:0] FEB_IDX    = 4'd1;
  localparam logic [4:0] FEB_LEAP   = 5'd29;

  typedef enum logic [5:0] {
    PH_IDLE  = 6'b000001,
    PH_DIV   = 6'b000010,
    PH_YEAR  = 6'b000100,
    PH_MONTH = 6'b001000,
    PH_TIME  = 6'b010000,
    PH_DONE  = 6'b100000
  } phase_e;

  typedef struct packed {
    phase_e              phase;
    logic [STEP_W-1:0]   step;
    logic                load;
  } cmd_t;

  typedef enum logic [2:0] {
    FLD_HOUR,
    FLD_MIN,
    FLD_SEC,
    FLD_MS,
    FLD_US
  } fld_e;

  typedef struct packed {
    logic [21:0] k;
    logic [13:0] w;
  } yr_step_t;

  typedef struct packed {
    logic [REM_W-1:0] k;
    fld_e             fld;
    logic [9:0]       w;
    logic [19:0]      uw;
  } tm_step_t;

  function automatic yr_step_t yr_step(input logic [3:0] s);
    yr_step_t   r;
    logic [2:0] sh;
    r  = '0;
    sh = '0;
    if (s inside {[4'd0:4'd4]}) begin
      sh  = 3'(4'd4 - s);
      r.k = DAYS_PER_400Y << sh;
      r.w = YEARS_400 << sh;
    end else if (s inside {[4'd5:4'd6]}) begin
      sh  = 3'(4'd6 - s);
      r.k = DAYS_PER_100Y << sh;
      r.w = YEARS_100 << sh;
    end else if (s inside {[4'd7:4'd11]}) begin
      sh  = 3'(4'd11 - s);
      r.k = DAYS_PER_4Y << sh;
      r.w = YEARS_4 << sh;
    end else if (s inside {[4'd12:4'd13]}) begin
      sh  = 3'(4'd13 - s);
      r.k = DAYS_PER_1Y << sh;
      r.w = YEARS_1 << sh;
    end
    return r;
  endfunction

  function automatic tm_step_t tm_step(input logic [STEP_W-1:0] s);
    tm_step_t   r;
    logic [3:0] sh;
    r     = '0;
    r.fld = FLD_US;
    sh    = '0;
    if (s inside {[6'd0:6'd4]}) begin
      sh    = 4'(6'd4 - s);
      r.k   = TICKS_PER_HOUR << sh;
      r.fld = FLD_HOUR;
      r.w   = 10'd1 << sh;
    end else if (s inside {[6'd5:6'd10]}) begin
      sh    = 4'(6'd10 - s);
      r.k   = TICKS_PER_MIN << sh;
      r.fld = FLD_MIN;
      r.w   = 10'd1 << sh;
    end else if (s inside {[6'd11:6'd16]}) begin
      sh    = 4'(6'd16 - s);
      r.k   = TICKS_PER_SEC << sh;
      r.fld = FLD_SEC;
      r.w   = 10'd1 << sh;
    end else if (s inside {[6'd17:6'd26]}) begin
      sh    = 4'(6'd26 - s);
      r.k   = TICKS_PER_MS << sh;
      r.fld = FLD_MS;
      r.w   = 10'd1 << sh;
      r.uw  = US_PER_MS << sh;
    end else if (s inside {[6'd27:6'd36]}) begin
      sh    = 4'(6'd36 - s);
      r.k   = TICKS_PER_US << sh;
      r.fld = FLD_US;
      r.uw  = 20'd1 << sh;
    end
    return r;
  endfunction

  // zero-based month index, april june september november are short
  function automatic logic [4:0] month_len(input logic [3:0] idx, input logic leap);
    logic [4:0] len;
    len = 5'd31;
    if (idx == FEB_IDX) begin
      len = leap ? FEB_LEAP : 5'd28;
    end else if (idx inside {4'd3, 4'd5, 4'd8, 4'd10}) begin
      len = 5'd30;
    end
    return len;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/tcf_sub.sv]
// shared compare and subtract unit used by every step of the conversion
`default_nettype none

module tcf_sub (
  input  logic [tcf_pkg::ALU_W-1:0] a_i,
  input  logic [tcf_pkg::ALU_W-1:0] b_i,
  output logic [tcf_pkg::ALU_W-1:0] diff_o,
  output logic                      ge_o
);
  import tcf_pkg::*;

  logic [ALU_W:0] full;

  assign full   = {1'b0, a_i} - {1'b0, b_i};
  assign diff_o = full[ALU_W-1:0];
  assign ge_o   = ~full[ALU_W];

endmodule

`default_nettype wire

[hw/rtl/tcf_ctrl.sv]
// step sequencer: walks the division, year, month and time phases
`default_nettype none

module tcf_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output tcf_pkg::cmd_t cmd_o
);
  import tcf_pkg::*;

  phase_e            phase_q, phase_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic              load;
  logic              last;

  assign load = start && (phase_q == PH_IDLE || phase_q == PH_DONE);

  always_comb begin
    last = 1'b0;
    case (phase_q)
      PH_DIV:   last = (step_q == STEP_W'(DIV_STEPS - 1));
      PH_YEAR:  last = (step_q == STEP_W'(YEAR_STEPS - 1));
      PH_MONTH: last = (step_q == STEP_W'(MONTH_STEPS - 1));
      PH_TIME:  last = (step_q == STEP_W'(TIME_STEPS - 1));
      default:  last = 1'b0;
    endcase
  end

  always_comb begin
    phase_d = phase_q;
    step_d  = last ? '0 : step_q + STEP_W'(1);
    case (phase_q)
      PH_IDLE: begin
        step_d = '0;
        if (load) phase_d = PH_DIV;
      end
      PH_DIV: begin
        if (last) phase_d = PH_YEAR;
      end
      PH_YEAR: begin
        if (last) phase_d = PH_MONTH;
      end
      PH_MONTH: begin
        if (last) phase_d = PH_TIME;
      end
      PH_TIME: begin
        if (last) phase_d = PH_DONE;
      end
      PH_DONE: begin
        step_d  = '0;
        phase_d = load ? PH_DIV : PH_IDLE;
      end
      default: begin
        step_d  = '0;
        phase_d = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      step_q  <= '0;
    end else begin
      phase_q <= phase_d;
      step_q  <= step_d;
    end
  end

  assign cmd_o.phase = phase_q;
  assign cmd_o.step  = step_q;
  assign cmd_o.load  = load;

endmodule

`default_nettype wire

[hw/rtl/tick_count_to_calendar_fields.sv]
// top level: tick count to calendar date and time of day converter
`default_nettype none

// Converts a 64-bit count of 100 ns ticks since 0001-01-01 00:00:00 into the
// Gregorian date and time of day. A word is taken when start is high and busy
// is low; busy then stays high while one compare-and-subtract unit is stepped
// 87 times: 25 steps of long division by the ticks in a day, 14 steps that
// strip 400, 100, 4 and 1 year spans, 11 month steps and 37 steps for hour,
// minute, second, millisecond and microsecond. The result shows for exactly
// one cycle with done_o high, once the last time step has run, and
// must be captured then: there is no way to hold it. A new word may be started
// in that same done cycle; no new word is taken while busy is high.
// Dates past 9999-12-31 give valid_res_o low and every field zero.
module tick_count_to_calendar_fields (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] tick_count_i,
  output logic        done_o,
  output logic        valid_res_o,
  output logic [13:0] year_o,
  output logic [3:0]  month_o,
  output logic [4:0]  day_o,
  output logic [4:0]  hour_o,
  output logic [5:0]  minute_o,
  output logic [5:0]  second_o,
  output logic [9:0]  millisecond_o,
  output logic [19:0] microsecond_o
);
  import tcf_pkg::*;

  cmd_t cmd;

  logic [DIV_STEPS-1:0] tick_q, tick_d;
  logic [REM_W-1:0]     rem_q, rem_d;
  logic [DAYS_W-1:0]    days_q, days_d;
  logic [13:0]          year_q, year_d;
  logic [HIST_W-1:0]    hist_q, hist_d;
  logic [3:0]           month_q, month_d;
  logic                 mstop_q, mstop_d;
  logic                 inval_q, inval_d;
  logic [4:0]           hour_q, hour_d;
  logic [5:0]           min_q, min_d;
  logic [5:0]           sec_q, sec_d;
  logic [9:0]           ms_q, ms_d;
  logic [19:0]          us_q, us_d;

  logic [ALU_W-1:0] alu_a, alu_b, alu_diff;
  logic             alu_ge;
  yr_step_t         ys;
  tm_step_t         ts;
  logic             leap;
  logic [4:0]       mlen;
  logic             ok;

  tcf_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .cmd_o  (cmd)
  );

  tcf_sub u_sub (
    .a_i    (alu_a),
    .b_i    (alu_b),
    .diff_o (alu_diff),
    .ge_o   (alu_ge)
  );

  assign ys   = yr_step(cmd.step[3:0]);
  assign ts   = tm_step(cmd.step);
  assign leap = (hist_q[1:0] == 2'b11) &&
                ((hist_q[6:2] != N4_CENTURY) || (hist_q[8:7] == 2'b11));
  assign mlen = month_len(month_q - 4'd1, leap);

  always_comb begin
    alu_a = '0;
    alu_b = '0;
    case (cmd.phase)
      PH_DIV: begin
        alu_a = {rem_q, tick_q[DIV_STEPS-1]};
        alu_b = {1'b0, DAY_TICKS};
      end
      PH_YEAR: begin
        alu_a = ALU_W'(days_q);
        alu_b = ALU_W'(ys.k);
      end
      PH_MONTH: begin
        alu_a = ALU_W'(days_q);
        alu_b = ALU_W'(mlen);
      end
      PH_TIME: begin
        alu_a = {1'b0, rem_q};
        alu_b = {1'b0, ts.k};
      end
      default: begin
        alu_a = '0;
        alu_b = '0;
      end
    endcase
  end

  always_comb begin
    tick_d  = tick_q;
    rem_d   = rem_q;
    days_d  = days_q;
    year_d  = year_q;
    hist_d  = hist_q;
    month_d = month_q;
    mstop_d = mstop_q;
    inval_d = inval_q;
    hour_d  = hour_q;
    min_d   = min_q;
    sec_d   = sec_q;
    ms_d    = ms_q;
    us_d    = us_q;
    if (cmd.load) begin
      tick_d  = tick_count_i[DIV_STEPS-1:0];
      rem_d   = REM_W'(tick_count_i[TICK_W-1:DIV_STEPS]);
      days_d  = '0;
      year_d  = 14'd1;
      hist_d  = '0;
      month_d = 4'd1;
      mstop_d = 1'b0;
      inval_d = 1'b0;
      hour_d  = '0;
      min_d   = '0;
      sec_d   = '0;
      ms_d    = '0;
      us_d    = '0;
    end else begin
      case (cmd.phase)
        PH_DIV: begin
          tick_d = {tick_q[DIV_STEPS-2:0], 1'b0};
          rem_d  = alu_ge ? alu_diff[REM_W-1:0] : alu_a[REM_W-1:0];
          days_d = {days_q[DAYS_W-2:0], alu_ge};
        end
        PH_YEAR: begin
          if (cmd.step == '0) inval_d = (days_q >= DAYS_LIMIT);
          hist_d = {hist_q[HIST_W-2:0], alu_ge};
          if (alu_ge) begin
            days_d = alu_diff[DAYS_W-1:0];
            year_d = year_q + ys.w;
          end
        end
        PH_MONTH: begin
          if (alu_ge && !mstop_q) begin
            days_d  = alu_diff[DAYS_W-1:0];
            month_d = month_q + 4'd1;
          end else begin
            mstop_d = 1'b1;
          end
        end
        PH_TIME: begin
          if (alu_ge) begin
            rem_d = alu_diff[REM_W-1:0];
            case (ts.fld)
              FLD_HOUR: hour_d = hour_q + ts.w[4:0];
              FLD_MIN:  min_d  = min_q + ts.w[5:0];
              FLD_SEC:  sec_d  = sec_q + ts.w[5:0];
              FLD_MS: begin
                ms_d = ms_q + ts.w;
                us_d = us_q + ts.uw;
              end
              FLD_US:   us_d   = us_q + ts.uw;
              default:  us_d   = us_q;
            endcase
          end
        end
        default: begin
          tick_d = tick_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    tick_q  <= tick_d;
    rem_q   <= rem_d;
    days_q  <= days_d;
    year_q  <= year_d;
    hist_q  <= hist_d;
    month_q <= month_d;
    hour_q  <= hour_d;
    min_q   <= min_d;
    sec_q   <= sec_d;
    ms_q    <= ms_d;
    us_q    <= us_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mstop_q <= 1'b0;
      inval_q <= 1'b0;
    end else begin
      mstop_q <= mstop_d;
      inval_q <= inval_d;
    end
  end

  assign ok   = ~inval_q;
  assign busy = ~(cmd.phase == PH_IDLE || cmd.phase == PH_DONE);

  assign done_o        = (cmd.phase == PH_DONE);
  assign valid_res_o   = ok;
  assign year_o        = ok ? year_q : '0;
  assign month_o       = ok ? month_q : '0;
  assign day_o         = ok ? (days_q[4:0] + 5'd1) : '0;
  assign hour_o        = ok ? hour_q : '0;
  assign minute_o      = ok ? min_q : '0;
  assign second_o      = ok ? sec_q : '0;
  assign millisecond_o = ok ? ms_q : '0;
  assign microsecond_o = ok ? us_q : '0;

endmodule

`default_nettype wire

[tb/tb_tick_count_to_calendar_fields.sv]
// testbench for the tick count to calendar converter: random and corner dates vs a predictor
`default_nettype none

module tb_tick_count_to_calendar_fields;

  localparam bit [63:0] TPD        = 64'd864000000000;
  localparam bit [63:0] TPH        = 64'd36000000000;
  localparam bit [63:0] TPM        = 64'd600000000;
  localparam bit [63:0] TPS        = 64'd10000000;
  localparam bit [63:0] TPMS       = 64'd10000;
  localparam bit [63:0] TPUS       = 64'd10;
  localparam bit [63:0] DAY_LIMIT  = 64'd3652059;
  localparam bit [63:0] DAYS_400Y  = 64'd146097;
  localparam bit [63:0] DAYS_100Y  = 64'd36524;
  localparam bit [63:0] DAYS_4Y    = 64'd1461;
  localparam bit [63:0] DAYS_1Y    = 64'd365;
  localparam int        N_RANDOM   = 2000;
  localparam int        MAX_CYCLES = 4000000;
  localparam int        DRAIN      = 100;

  typedef struct packed {
    bit        ok;
    bit [13:0] year;
    bit [3:0]  month;
    bit [4:0]  day;
    bit [4:0]  hour;
    bit [5:0]  minute;
    bit [5:0]  second;
    bit [9:0]  milli;
    bit [19:0] micro;
  } calendar_t;

  typedef struct packed {
    bit [63:0] ticks;
    calendar_t cal;
  } conversion_t;

  logic        clk_i;
  logic        rst_ni;
  logic        start = 1'b0;
  logic        busy;
  logic [63:0] tick_count = '0;
  logic        done_o;
  logic        valid_res_o;
  logic [13:0] year_o;
  logic [3:0]  month_o;
  logic [4:0]  day_o;
  logic [4:0]  hour_o;
  logic [5:0]  minute_o;
  logic [5:0]  second_o;
  logic [9:0]  millisecond_o;
  logic [19:0] microsecond_o;

  // queues fill at the front and drain from the back
  bit [63:0]   tick_words[$];
  conversion_t dates_due[$];
  int unsigned idle_left = 0;
  int unsigned calm_left = 0;
  int          n_words;
  int          n_accepted = 0;
  int          n_in_range = 0;
  int          n_past_end = 0;
  int          errors = 0;
  int          cycles = 0;

  tick_count_to_calendar_fields u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .tick_count_i  (tick_count),
    .done_o        (done_o),
    .valid_res_o   (valid_res_o),
    .year_o        (year_o),
    .month_o       (month_o),
    .day_o         (day_o),
    .hour_o        (hour_o),
    .minute_o      (minute_o),
    .second_o      (second_o),
    .millisecond_o (millisecond_o),
    .microsecond_o (microsecond_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic bit is_leap(bit [63:0] y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic bit [63:0] month_length(int unsigned m, bit [63:0] y);
    bit [63:0] len;
    case (m)
      2:       len = is_leap(y) ? 64'd29 : 64'd28;
      4, 6, 9, 11: len = 64'd30;
      default: len = 64'd31;
    endcase
    return len;
  endfunction

  function automatic calendar_t to_calendar(bit [63:0] ticks);
    calendar_t   c;
    bit [63:0]   d;
    bit [63:0]   r;
    bit [63:0]   q400;
    bit [63:0]   q100;
    bit [63:0]   q4;
    bit [63:0]   q1;
    bit [63:0]   y;
    int unsigned m;
    c = '0;
    d = ticks / TPD;
    r = ticks % TPD;
    if (d < DAY_LIMIT) begin
      q400 = d / DAYS_400Y;
      d    = d % DAYS_400Y;
      q100 = d / DAYS_100Y;
      if (q100 == 4) q100 = 3;
      d    = d - q100 * DAYS_100Y;
      q4   = d / DAYS_4Y;
      d    = d % DAYS_4Y;
      q1   = d / DAYS_1Y;
      if (q1 == 4) q1 = 3;
      d    = d - q1 * DAYS_1Y;
      y    = 400 * q400 + 100 * q100 + 4 * q4 + q1 + 1;
      m    = 1;
      while (m < 12 && d >= month_length(m, y)) begin
        d = d - month_length(m, y);
        m++;
      end
      c.ok     = 1'b1;
      c.year   = y[13:0];
      c.month  = m[3:0];
      c.day    = 5'(d + 1);
      c.hour   = 5'(r / TPH);
      r        = r % TPH;
      c.minute = 6'(r / TPM);
      r        = r % TPM;
      c.second = 6'(r / TPS);
      r        = r % TPS;
      c.milli  = 10'(r / TPMS);
      c.micro  = 20'(r / TPUS);
    end
    return c;
  endfunction

  function automatic bit [63:0] jan1_day(bit [63:0] y);
    return (y - 1) * 365 + (y - 1) / 4 - (y - 1) / 100 + (y - 1) / 400;
  endfunction

  function automatic bit [63:0] at_day(bit [63:0] d, bit [63:0] r);
    return d * TPD + r;
  endfunction

  function automatic bit [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic int unsigned pick_idle();
    int unsigned r;
    if (calm_left != 0) begin
      calm_left = calm_left - 1;
      return 0;
    end
    if ($urandom_range(0, 49) == 0) calm_left = $urandom_range(10, 40);
    r = $urandom_range(0, 99);
    if (r < 30) return 0;
    if (r < 75) return $urandom_range(1, 8);
    if (r < 93) return $urandom_range(9, 90);
    return $urandom_range(91, 400);
  endfunction

  task automatic check_field(bit [63:0] ticks, string name, logic [19:0] want, logic [19:0] seen);
    if (seen !== want) begin
      errors++;
      $display("%0t: tick %0d: %s expected %0d got %0d", $time, ticks, name, want, seen);
    end
  endtask

  always @(posedge clk_i) begin
    conversion_t pend;
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        pend.ticks = tick_count;
        pend.cal   = to_calendar(tick_count);
        dates_due.push_front(pend);
        n_accepted++;
      end
      if (start && busy) begin
      end else if (idle_left != 0) begin
        start     <= 1'b0;
        idle_left <= idle_left - 1;
      end else if (tick_words.size() != 0) begin
        start      <= 1'b1;
        tick_count <= tick_words.pop_back();
        idle_left  <= pick_idle();
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    conversion_t e;
    if (rst_ni && done_o) begin
      if (dates_due.size() == 0) begin
        errors++;
        $display("%0t: result with no word pending, expected none got year %0d", $time, year_o);
      end else begin
        e = dates_due.pop_back();
        if (e.cal.ok) n_in_range++;
        else n_past_end++;
        check_field(e.ticks, "valid_res", e.cal.ok, valid_res_o);
        check_field(e.ticks, "year", e.cal.year, year_o);
        check_field(e.ticks, "month", e.cal.month, month_o);
        check_field(e.ticks, "day", e.cal.day, day_o);
        check_field(e.ticks, "hour", e.cal.hour, hour_o);
        check_field(e.ticks, "minute", e.cal.minute, minute_o);
        check_field(e.ticks, "second", e.cal.second, second_o);
        check_field(e.ticks, "millisecond", e.cal.milli, millisecond_o);
        check_field(e.ticks, "microsecond", e.cal.micro, microsecond_o);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= MAX_CYCLES) begin
      $display("timeout after %0d cycles, %0d of %0d words accepted", cycles, n_accepted, n_words);
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    longint      d;
    int unsigned kind;
    int unsigned y;
    bit [63:0]   r;
    int          offs[9];
    offs = '{-1, 0, 30, 31, 58, 59, 60, 364, 365};
    rst_ni = 1'b0;

    tick_words.push_front(64'd0);
    tick_words.push_front(64'd9);
    tick_words.push_front(64'd10);
    tick_words.push_front(64'd9999);
    tick_words.push_front(64'd10000);
    tick_words.push_front(TPD - 1);
    tick_words.push_front('1);
    tick_words.push_front(64'h8000_0000_0000_0000);
    tick_words.push_front(at_day(DAY_LIMIT, 0) - 1);
    tick_words.push_front(at_day(DAY_LIMIT, 0));
    tick_words.push_front(at_day(58, TPD - 1));
    tick_words.push_front(at_day(59, 0));
    tick_words.push_front(at_day(jan1_day(2000) + 59, 64'd123456789));
    tick_words.push_front(at_day(jan1_day(1900) + 58, TPD - 1));
    tick_words.push_front(at_day(jan1_day(1900) + 59, 0));
    tick_words.push_front(at_day(146096, TPD - 1));
    tick_words.push_front(at_day(146097, 0));
    tick_words.push_front(at_day(1460, 64'd5));
    tick_words.push_front(at_day(1461, 0));
    tick_words.push_front(at_day(36523, TPD - 1));
    tick_words.push_front(at_day(36524, 0));
    tick_words.push_front(at_day(jan1_day(2024) + 365, 12 * TPH + 34 * TPM + 56 * TPS + 7891234));
    tick_words.push_front(at_day(jan1_day(9999), 0));

    for (int i = 0; i < N_RANDOM; i++) begin
      kind = $urandom_range(0, 99);
      if (kind < 55) begin
        tick_words.push_front(at_day($urandom_range(0, 3652058), rand64() % TPD));
      end else if (kind < 80) begin
        y = $urandom_range(1, 9999);
        d = longint'(jan1_day(y)) + offs[$urandom_range(0, 8)];
        if (d < 0) d = 0;
        if (d >= longint'(DAY_LIMIT)) d = longint'(DAY_LIMIT) - 1;
        case ($urandom_range(0, 2))
          0:       r = 0;
          1:       r = TPD - 1;
          default: r = rand64() % TPD;
        endcase
        tick_words.push_front(at_day(d, r));
      end else if (kind < 90) begin
        tick_words.push_front(at_day(DAY_LIMIT - 3 + $urandom_range(0, 5), rand64() % TPD));
      end else begin
        tick_words.push_front(rand64() >> $urandom_range(0, 63));
      end
    end
    n_words = tick_words.size();

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (n_accepted < n_words) @(posedge clk_i);
    while (dates_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);

    $display("converted %0d tick counts in %0d cycles: %0d dates in range, %0d past year 9999",
             n_words, cycles, n_in_range, n_past_end);
    $display("corners: leap days, century and 400-year edges, last valid tick, sub-microsecond ticks");
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches", errors);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
